@@ rtl/sm3_pkg.sv @@
// sm3_pkg: constants, types and helper functions for the SM3 hash engine.
// Used by: sm3_hash_engine. No dependencies.

package sm3_pkg;

	localparam int LENGTH_BITS_DEF = 64;

	localparam logic [31:0] T_LOW  = 32'h79cc_4519;
	localparam logic [31:0] T_HIGH = 32'h7a87_9d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [31:0] IV [8] = '{
		32'h7380_166f, 32'h4914_b2b9, 32'h1724_42d7, 32'hda8a_0600,
		32'ha96f_30bc, 32'h1631_38aa, 32'he38d_ee4d, 32'hb0fb_0e4e
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// which compression is running
	typedef enum logic [1:0] {
		PH_DATA,
		PH_PAD1,
		PH_FINAL
	} phase_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] k);
		logic [63:0] t;
		t = {x, x} << k;
		return t[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
	endfunction

endpackage

@@ rtl/sm3_hash_engine.sv @@
// sm3_hash_engine: streaming SM3 hash, one message byte per transfer, 256-bit digest
// as eight word transfers. Depends on sm3_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   input   | in_valid / in_ready | data_byte, byte_present, end_of_message
//   output  | out_valid/out_ready | digest_word, word_index, last_word
//
// Filling a block starts a compression: a load step, 64 rounds on the single round
// unit and a fold step, during which in_ready is low. End of message adds a pad step
// and one or two compressions, then eight output transfers, paced by out_ready.
// Reset loads the IV and clears buffer and length; no clearing pass.

module sm3_hash_engine #(
	parameter int LENGTH_BITS = sm3_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [63:0] LenMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

	sm3_pkg::state_t state_q, state_d;
	sm3_pkg::phase_t phase_q;

	logic [31:0] cv_q [8];
	logic [31:0] buf_q [16];
	logic [63:0] count_q;
	logic        eom_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic [31:0] win_q [16];
	logic [31:0] wr_q [8];

	logic        in_xfer, out_xfer;
	logic        blk_full;
	logic [5:0]  pos;
	logic [63:0] len_bits;
	logic [31:0] pad_buf [16];

	logic [31:0] a12, t_rot, ss1, ss2, ff, gg, tt1, tt2, w_new, wj, wpj;

	assign in_xfer  = in_valid & in_ready;
	assign out_xfer = out_valid & out_ready;
	assign blk_full = byte_present & (count_q[5:0] == 6'd63);
	assign pos      = count_q[5:0];
	assign len_bits = {count_q[60:0], 3'b000} & LenMask;

	// outputs
	always_comb begin
		in_ready  = (state_q == sm3_pkg::ST_IDLE);
		out_valid = (state_q == sm3_pkg::ST_EMIT);
	end

	assign digest_word = cv_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sm3_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (blk_full)
						state_d = sm3_pkg::ST_LOAD;
					else if (end_of_message)
						state_d = sm3_pkg::ST_PAD;
				end
			end
			sm3_pkg::ST_PAD:   state_d = sm3_pkg::ST_LOAD;
			sm3_pkg::ST_LOAD:  state_d = sm3_pkg::ST_ROUND;
			sm3_pkg::ST_ROUND: begin
				if (round_q == 6'd63)
					state_d = sm3_pkg::ST_FOLD;
			end
			sm3_pkg::ST_FOLD: begin
				unique case (phase_q)
					sm3_pkg::PH_DATA:  state_d = eom_q ? sm3_pkg::ST_PAD : sm3_pkg::ST_IDLE;
					sm3_pkg::PH_PAD1:  state_d = sm3_pkg::ST_LOAD;
					sm3_pkg::PH_FINAL: state_d = sm3_pkg::ST_EMIT;
					default:           state_d = sm3_pkg::ST_IDLE;
				endcase
			end
			sm3_pkg::ST_EMIT: begin
				if (out_xfer && idx_q == 3'd7)
					state_d = sm3_pkg::ST_IDLE;
			end
			default: state_d = sm3_pkg::ST_IDLE;
		endcase
	end

	// padded block: 0x80 at pos, zeros after; length when it fits
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			for (int b = 0; b < 4; b++) begin
				if (6'(w * 4 + b) == pos)
					pad_buf[w][(3 - b) * 8 +: 8] = sm3_pkg::PAD_BYTE;
				else if (6'(w * 4 + b) > pos)
					pad_buf[w][(3 - b) * 8 +: 8] = 8'h00;
				else
					pad_buf[w][(3 - b) * 8 +: 8] = buf_q[w][(3 - b) * 8 +: 8];
			end
		end
		if (pos < 6'd56) begin
			pad_buf[14] = len_bits[63:32];
			pad_buf[15] = len_bits[31:0];
		end
	end

	// round unit
	always_comb begin
		a12   = sm3_pkg::rotl32(wr_q[0], 5'd12);
		t_rot = sm3_pkg::rotl32((round_q < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH,
			round_q[4:0]);
		ss1   = sm3_pkg::rotl32(a12 + wr_q[4] + t_rot, 5'd7);
		ss2   = ss1 ^ a12;
		if (round_q < 6'd16) begin
			ff = wr_q[0] ^ wr_q[1] ^ wr_q[2];
			gg = wr_q[4] ^ wr_q[5] ^ wr_q[6];
		end else begin
			ff = (wr_q[0] & wr_q[1]) | (wr_q[0] & wr_q[2]) | (wr_q[1] & wr_q[2]);
			gg = (wr_q[4] & wr_q[5]) | (~wr_q[4] & wr_q[6]);
		end
		wj    = win_q[0];
		wpj   = win_q[0] ^ win_q[4];
		tt1   = ff + wr_q[3] + ss2 + wpj;
		tt2   = gg + wr_q[7] + ss1 + wj;
		w_new = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl32(win_q[13], 5'd15))
			^ sm3_pkg::rotl32(win_q[3], 5'd7) ^ win_q[10];
	end

	// control and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm3_pkg::ST_IDLE;
			phase_q <= sm3_pkg::PH_DATA;
			eom_q   <= 1'b0;
			round_q <= '0;
			idx_q   <= '0;
			count_q <= '0;
			for (int i = 0; i < 8; i++)
				cv_q[i] <= sm3_pkg::IV[i];
			for (int i = 0; i < 16; i++)
				buf_q[i] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sm3_pkg::ST_IDLE: begin
					if (in_xfer) begin
						eom_q   <= end_of_message;
						phase_q <= sm3_pkg::PH_DATA;
						if (byte_present) begin
							buf_q[count_q[5:2]][{~count_q[1:0], 3'b000} +: 8] <= data_byte;
							count_q <= count_q + 64'd1;
						end
					end
				end
				sm3_pkg::ST_PAD: begin
					for (int i = 0; i < 16; i++)
						buf_q[i] <= pad_buf[i];
					phase_q <= (pos < 6'd56) ? sm3_pkg::PH_FINAL : sm3_pkg::PH_PAD1;
				end
				sm3_pkg::ST_LOAD: round_q <= '0;
				sm3_pkg::ST_ROUND: round_q <= round_q + 6'd1;
				sm3_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++)
						cv_q[i] <= cv_q[i] ^ wr_q[i];
					idx_q <= '0;
					if (phase_q == sm3_pkg::PH_PAD1) begin
						for (int i = 0; i < 14; i++)
							buf_q[i] <= '0;
						buf_q[14] <= len_bits[63:32];
						buf_q[15] <= len_bits[31:0];
						phase_q   <= sm3_pkg::PH_FINAL;
					end
				end
				sm3_pkg::ST_EMIT: begin
					if (out_xfer) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								cv_q[i] <= sm3_pkg::IV[i];
							for (int i = 0; i < 16; i++)
								buf_q[i] <= '0;
							count_q <= '0;
							eom_q   <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// working registers and W window (shifts one word per round)
	always_ff @(posedge clk) begin
		if (state_q == sm3_pkg::ST_LOAD) begin
			for (int i = 0; i < 16; i++)
				win_q[i] <= buf_q[i];
			for (int i = 0; i < 8; i++)
				wr_q[i] <= cv_q[i];
		end else if (state_q == sm3_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				win_q[i] <= win_q[i + 1];
			win_q[15] <= w_new;
			wr_q[0] <= tt1;
			wr_q[1] <= wr_q[0];
			wr_q[2] <= sm3_pkg::rotl32(wr_q[1], 5'd9);
			wr_q[3] <= wr_q[2];
			wr_q[4] <= sm3_pkg::perm0(tt2);
			wr_q[5] <= wr_q[4];
			wr_q[6] <= sm3_pkg::rotl32(wr_q[5], 5'd19);
			wr_q[7] <= wr_q[6];
		end
	end

endmodule
